[hdl/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int DATA_W        = 8;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 rd_en;
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 is_empty;
  } rsp_info_t;

endpackage

[hdl/deq_ram.sv]
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hdl/deq_ctrl.sv]
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [OP_W-1:0]          op,
  input  logic [DATA_W-1:0]        push_value,
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output logic [DATA_W-1:0]        mem_wdata,
  output rsp_info_t                info
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] rear, rear_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic             full, empty, we, re;
  status_t          status;

  assign front_inc = (front == LAST) ? '0 : front + IDX_W'(1);
  assign front_dec = (front == '0) ? LAST : front - IDX_W'(1);
  assign rear_inc  = (rear == LAST) ? '0 : rear + IDX_W'(1);
  assign rear_dec  = (rear == '0) ? LAST : rear - IDX_W'(1);
  assign full      = (cnt == FULL_CNT);
  assign empty     = (cnt == '0);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    cnt_next   = cnt;
    we         = 1'b0;
    re         = 1'b0;
    mem_addr   = front;
    status     = ST_OK;
    unique case (op)
      OP_PUSH_FRONT: begin
        mem_addr = front_dec;
        if (full) begin
          status = ST_FULL;
        end else begin
          we         = 1'b1;
          front_next = front_dec;
          cnt_next   = cnt + CNT_W'(1);
        end
      end
      OP_PUSH_REAR: begin
        mem_addr = rear;
        if (full) begin
          status = ST_FULL;
        end else begin
          we        = 1'b1;
          rear_next = rear_inc;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        mem_addr = front;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re         = 1'b1;
          front_next = front_inc;
          cnt_next   = cnt - CNT_W'(1);
        end
      end
      OP_POP_REAR: begin
        mem_addr = rear_dec;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re        = 1'b1;
          rear_next = rear_dec;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      OP_PEEK_FRONT: begin
        mem_addr = front;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re = 1'b1;
        end
      end
      OP_PEEK_REAR: begin
        mem_addr = rear_dec;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          re = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign mem_en        = accept & (we | re);
  assign mem_we        = accept & we;
  assign mem_wdata     = push_value;
  assign info.rd_en    = re;
  assign info.status   = status;
  assign info.count    = COUNT_W'(cnt_next);
  assign info.is_empty = (cnt_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      cnt   <= '0;
    end else if (accept) begin
      front <= front_next;
      rear  <= rear_next;
      cnt   <= cnt_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_CNT)
    else $error("entry count exceeds depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (cnt == '0 || cnt == FULL_CNT) |-> front == rear)
    else $error("pointers disagree with count at empty or full");
`endif

endmodule

[hdl/double_ended_queue_core.sv]
// Double-ended queue of 8-bit words in a ring buffer of DEPTH entries held in
// one single-port synchronous RAM. Each request transaction pushes or pops at
// either end, or peeks at either end, and returns exactly one result
// transaction with status (ok, empty, full), the word read, the entry count
// after the request and an empty flag. Pointers and count update at request
// acceptance; the RAM read is registered, and no new request is accepted while
// an accepted one is still in the read stage. While a finished result waits in
// the output register under stall, requests are held off; the next request is
// accepted no earlier than the edge at which that result is taken. A push to a
// full queue is refused with status full; a pop or peek on an empty queue
// returns status empty and zero. Other op codes change nothing and return
// status ok and zero.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [DATA_W-1:0]   push_value,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   read_value,
  output logic [COUNT_W-1:0]  element_count,
  output logic                is_empty
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                accept;
  logic                mem_en, mem_we;
  logic [IDX_W-1:0]    mem_addr;
  logic [DATA_W-1:0]   mem_wdata, mem_rdata;
  rsp_info_t           info;
  logic                s1_valid;
  rsp_info_t           s1_info;

  assign req_stall = s1_valid | (rsp_valid & rsp_stall);
  assign accept    = req_valid & ~req_stall;

  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .push_value(push_value),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .info      (info)
  );

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      status        <= s1_info.status;
      read_value    <= s1_info.rd_en ? mem_rdata : '0;
      element_count <= s1_info.count;
      is_empty      <= s1_info.is_empty;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_free: assert property (@(posedge clk) disable iff (rst) s1_valid |-> !rsp_valid)
    else $error("result register occupied when read data arrives");
  a_accept_adv: assert property (@(posedge clk) disable iff (rst) accept |=> s1_valid)
    else $error("accepted transaction lost before read stage");
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && status == ST_FULL) |-> element_count == COUNT_W'(DEPTH))
    else $error("full status with queue not full");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && status == ST_EMPTY) |-> (is_empty && read_value == '0))
    else $error("empty status with data or entries");
`endif

endmodule
